>>> rtl/rfb_pkg.sv
// Shared types and constants for the gradient rectangle fill pixel core.
// Used by every module under rtl.
package rfb_pkg;

  localparam int SURFACE_WIDTH  = 1024;
  localparam int SURFACE_HEIGHT = 1024;

  localparam logic [1:0] MODE_FILL  = 2'd0;
  localparam logic [1:0] MODE_BLEND = 2'd1;
  localparam logic [1:0] MODE_HGRAD = 2'd2;
  localparam logic [1:0] MODE_VGRAD = 2'd3;

  localparam logic [2:0] REG_LEFT   = 3'd0;
  localparam logic [2:0] REG_TOP    = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_HEIGHT = 3'd3;
  localparam logic [2:0] REG_START  = 3'd4;
  localparam logic [2:0] REG_END    = 3'd5;
  localparam logic [2:0] REG_MODE   = 3'd6;

  localparam logic [1:0] PICK_DST   = 2'd0;
  localparam logic [1:0] PICK_SRC   = 2'd1;
  localparam logic [1:0] PICK_BLEND = 2'd2;

  localparam logic [16:0] DIV255_MUL = 17'h08081;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [31:0]        start_color;
    logic [31:0]        end_color;
    logic [1:0]         mode;
  } cfg_t;

  typedef struct packed {
    logic        cov;
    logic [1:0]  mode;
    logic [31:0] dst;
  } side_t;

endpackage

>>> rtl/rfb_cover.sv
// First pipeline stage: coverage test and clamped gradient offset.
// Depends on rfb_pkg.
module rfb_cover (
  input  logic          clk,
  input  logic          en,
  input  rfb_pkg::cfg_t cfg,
  input  logic [13:0]   px,
  input  logic [13:0]   py,
  input  logic [31:0]   dst,
  output rfb_pkg::side_t side,
  output logic [14:0]   t,
  output logic [14:0]   span
);
  import rfb_pkg::*;

  logic signed [16:0] px_s, py_s, hx, hy, traw;
  logic               cov_x, cov_y, vert;
  logic [13:0]        p;
  logic signed [15:0] o;
  logic [14:0]        len, span_c, t_c;

  always_comb begin
    px_s = $signed({3'b000, px});
    py_s = $signed({3'b000, py});
    hx = $signed({cfg.left[15], cfg.left}) + $signed({2'b00, cfg.width});
    hy = $signed({cfg.top[15], cfg.top}) + $signed({2'b00, cfg.height});
    cov_x = (cfg.width != 15'd0) && (cfg.left[15] || px_s >= $signed({cfg.left[15], cfg.left}))
            && (px_s < hx) && ({1'b0, px} < 15'(SURFACE_WIDTH));
    cov_y = (cfg.height != 15'd0) && (cfg.top[15] || py_s >= $signed({cfg.top[15], cfg.top}))
            && (py_s < hy) && ({1'b0, py} < 15'(SURFACE_HEIGHT));
    vert = (cfg.mode == MODE_VGRAD);
    p    = vert ? py : px;
    o    = vert ? cfg.top : cfg.left;
    len  = vert ? cfg.height : cfg.width;
    span_c = (len <= 15'd1) ? 15'd1 : len - 15'd1;
    traw = $signed({3'b000, p}) - $signed({o[15], o});
    if (traw[16]) begin
      t_c = 15'd0;
    end else if (traw > $signed({2'b00, span_c})) begin
      t_c = span_c;
    end else begin
      t_c = traw[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side.cov  <= cov_x && cov_y;
      side.mode <= cfg.mode;
      side.dst  <= dst;
      t         <= t_c;
      span      <= span_c;
    end
  end

endmodule

>>> rtl/rfb_lerp_lane.sv
// One color channel of the gradient: product, 8-bit restoring divide over
// four stages (two bits each), then signed add. Depends on rfb_pkg.
module rfb_lerp_lane (
  input  logic        clk,
  input  logic        en,
  input  logic [7:0]  ca,
  input  logic [7:0]  cb,
  input  logic [14:0] t,
  input  logic [14:0] span,
  output logic [7:0]  ch
);
  import rfb_pkg::*;

  logic [22:0] num [0:4];
  logic [7:0]  quo [0:4];
  logic [14:0] dvs [0:3];
  logic [7:0]  base [0:4];
  logic        neg [0:4];

  logic [22:0] num_next [1:4];
  logic [7:0]  quo_next [1:4];
  logic [22:0] n_mid, s_hi, s_lo;
  logic [7:0]  q_mid;
  logic signed [8:0] diff;
  logic [7:0]  mag;

  always_comb begin
    diff = $signed({1'b0, cb}) - $signed({1'b0, ca});
    mag  = diff[8] ? 8'(-diff) : diff[7:0];
    for (int k = 0; k < 4; k++) begin
      s_hi  = 23'({8'd0, dvs[k]} << (7 - 2 * k));
      s_lo  = 23'({8'd0, dvs[k]} << (6 - 2 * k));
      n_mid = num[k];
      q_mid = quo[k];
      if (n_mid >= s_hi) begin
        n_mid = n_mid - s_hi;
        q_mid[7 - 2 * k] = 1'b1;
      end
      if (n_mid >= s_lo) begin
        n_mid = n_mid - s_lo;
        q_mid[6 - 2 * k] = 1'b1;
      end
      num_next[k + 1] = n_mid;
      quo_next[k + 1] = q_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num[0]  <= {15'd0, mag} * {8'd0, t};
      quo[0]  <= 8'd0;
      dvs[0]  <= span;
      base[0] <= ca;
      neg[0]  <= diff[8];
      for (int k = 1; k < 5; k++) begin
        num[k]  <= num_next[k];
        quo[k]  <= quo_next[k];
        base[k] <= base[k - 1];
        neg[k]  <= neg[k - 1];
      end
      for (int k = 1; k < 4; k++) begin
        dvs[k] <= dvs[k - 1];
      end
      ch <= neg[4] ? base[4] - quo[4] : base[4] + quo[4];
    end
  end

endmodule

>>> rtl/rfb_blend.sv
// Source-over composite over two stages: channel products, then divide
// by 255 through a reciprocal multiply and output select. Depends on rfb_pkg.
module rfb_blend (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   src,
  input  rfb_pkg::side_t side,
  output logic [31:0]   pixel,
  output logic          cov
);
  import rfb_pkg::*;

  logic [7:0]  sa, inv;
  logic [1:0]  pick_c, pick;
  logic [15:0] sum [0:2];
  logic [31:0] src_q, dst_q;
  logic        cov_q;
  logic [32:0] prod [0:2];
  logic [7:0]  q [0:2];

  always_comb begin
    sa  = src[31:24];
    inv = 8'd255 - sa;
    if (!side.cov || (side.mode != MODE_FILL && sa == 8'd0)) begin
      pick_c = PICK_DST;
    end else if (side.mode == MODE_FILL || sa == 8'd255) begin
      pick_c = PICK_SRC;
    end else begin
      pick_c = PICK_BLEND;
    end
    for (int c = 0; c < 3; c++) begin
      prod[c] = {17'd0, sum[c]} * {16'd0, DIV255_MUL};
      q[c]    = prod[c][30:23];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        sum[c] <= {8'd0, src[8 * c +: 8]} * {8'd0, sa}
                  + {8'd0, side.dst[8 * c +: 8]} * {8'd0, inv};
      end
      pick  <= pick_c;
      src_q <= src;
      dst_q <= side.dst;
      cov_q <= side.cov;
      cov   <= cov_q;
      case (pick)
        PICK_DST: pixel <= dst_q;
        PICK_SRC: pixel <= src_q;
        default:  pixel <= {8'hFF, q[2], q[1], q[0]};
      endcase
    end
  end

endmodule

>>> rtl/rect_fill_blend_gradient_pixel_core.sv
// Rectangle fill with source-over blend and linear gradient, one pixel a beat.
// Beats pass through cover, gradient and blend stages; throughput one beat per
// cycle when not stalled, set by a fully pipelined datapath with a 4-stage
// restoring divider. The whole pipeline holds while the output beat waits.
// Synchronous active-high rst clears valid bits and config registers to 0.
module rect_fill_blend_gradient_pixel_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // pixel_x[13:0], pixel_y[27:14], dest_pixel[59:28]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_pixel[31:0]
  output logic        m_tuser    // write_enable[0]
);
  import rfb_pkg::*;

  cfg_t        cfg;
  logic        en;
  logic [7:0]  valid;
  side_t       side [0:6];
  logic [14:0] t, span;
  logic [31:0] grad, src;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT:   cfg.left        <= cfg_data[15:0];
        REG_TOP:    cfg.top         <= cfg_data[15:0];
        REG_WIDTH:  cfg.width       <= cfg_data[14:0];
        REG_HEIGHT: cfg.height      <= cfg_data[14:0];
        REG_START:  cfg.start_color <= cfg_data;
        REG_END:    cfg.end_color   <= cfg_data;
        REG_MODE:   cfg.mode        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      valid    <= {valid[6:0], s_tvalid};
      m_tvalid <= valid[7];
    end
  end

  rfb_cover u_cover (
    .clk (clk), .en (en), .cfg (cfg),
    .px (s_tdata[13:0]), .py (s_tdata[27:14]), .dst (s_tdata[59:28]),
    .side (side[0]), .t (t), .span (span)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k < 7; k++) begin
        side[k] <= side[k - 1];
      end
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    rfb_lerp_lane u_lane (
      .clk (clk), .en (en),
      .ca (cfg.start_color[8 * c +: 8]), .cb (cfg.end_color[8 * c +: 8]),
      .t (t), .span (span), .ch (grad[8 * c +: 8])
    );
  end

  assign src = (side[6].mode == MODE_HGRAD || side[6].mode == MODE_VGRAD) ? grad
                                                                          : cfg.start_color;

  rfb_blend u_blend (
    .clk (clk), .en (en), .src (src), .side (side[6]),
    .pixel (m_tdata), .cov (m_tuser)
  );

endmodule
